FILE: hdl/dmrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrf_pkg
// Shared types and constants for the delimited message receive FIFO.
// ----------------------------------------------------------------------------
package dmrf_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam logic [7:0]  DELIM_RESET = 8'd36;   // '$'
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_CONSUME = 2'd2
  } dmrf_cmd_t;

  typedef struct packed {
    logic [7:0] message_count;
    logic       overflowed;
    logic       was_empty;
    logic [7:0] data_out;
  } dmrf_result_t;

endpackage

FILE: hdl/dmrf_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrf_mem
// Byte store: one write port, one read port with registered read data.
// A write to the address being read is forwarded to the read register.
// ----------------------------------------------------------------------------
module dmrf_mem #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/dmrf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrf_core
// FIFO indices, message counter and the per-command update logic.
// ----------------------------------------------------------------------------
module dmrf_core
  import dmrf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [1:0]   cmd,
  input  logic [7:0]   byte_in,
  input  logic [7:0]   delimiter,
  output dmrf_result_t result
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]    count_r, count_nxt;
  logic [AW-1:0] wr_inc, wr_dec, rd_inc;
  logic          empty, full;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_q;

  assign wr_inc = (wr_idx_r == LAST) ? '0 : wr_idx_r + 1'b1;
  assign wr_dec = (wr_idx_r == '0) ? LAST : wr_idx_r - 1'b1;
  assign rd_inc = (rd_idx_r == LAST) ? '0 : rd_idx_r + 1'b1;
  assign empty  = (wr_idx_r == rd_idx_r);
  assign full   = (wr_inc == rd_idx_r);

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    mem_waddr  = wr_idx_r;
    mem_wdata  = byte_in;
    result     = '0;
    result.was_empty = empty;
    case (cmd)
      CMD_PUSH: begin
        if (full) begin
          // no room: terminate the message in the last slot written
          mem_we     = fire;
          mem_waddr  = wr_dec;
          mem_wdata  = delimiter;
          result.overflowed = 1'b1;
          if (count_r != COUNT_MAX) count_nxt = count_r + 8'd1;
        end else begin
          mem_we     = fire;
          wr_idx_nxt = wr_inc;
          if (byte_in == delimiter && count_r != COUNT_MAX) count_nxt = count_r + 8'd1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          result.data_out = delimiter;
        end else begin
          result.data_out = mem_q;
          rd_idx_nxt      = rd_inc;
        end
      end
      CMD_CONSUME: begin
        if (count_r != 8'd0) count_nxt = count_r - 8'd1;
      end
      default: ;
    endcase
    result.message_count = count_nxt;
    if (!fire) begin
      wr_idx_nxt = wr_idx_r;
      rd_idx_nxt = rd_idx_r;
      count_nxt  = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // read address runs one step ahead so the head byte is ready next cycle
  dmrf_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_nxt),
    .rdata (mem_q)
  );

endmodule

FILE: hdl/delimited_message_rx_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_message_rx_fifo_top
// Receive FIFO for delimiter-terminated messages, one result per command.
// ----------------------------------------------------------------------------
// Input stream: in_tuser carries the command (push, pop, consume), in_tdata
// the byte to push. Every accepted beat produces exactly one result beat on
// the output stream: popped byte, was-empty and overflow flags and the count
// of complete messages held after the command.
// cfg_wr_en/cfg_wr_data set the delimiter byte (reset value '$'); write it
// only while no command is in flight.
// An input beat reaches its result beat through one input register, then the
// update logic into the result register. One command is taken every cycle
// while the receiver takes results; the byte store's registered read is fed
// from the next read index, so back-to-back pops need no bubble.
// A stalled receiver holds the result register; the input register then
// holds one more beat and in_tready drops until the result is taken.
// Synchronous reset empties the FIFO, clears the message count and restores
// the delimiter; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module delimited_message_rx_fifo_top
  import dmrf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] data_out, [8] was_empty, [9] overflowed, [17:10] message_count,
  // [23:18] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic         in_valid_r;
  logic [1:0]   in_cmd_r;
  logic [7:0]   in_byte_r;
  logic         out_valid_r;
  dmrf_result_t out_res_r;
  dmrf_result_t result;
  logic [7:0]   delim_r;
  logic         fire;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (cfg_wr_en) begin
      delim_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= result;
    end
  end

  dmrf_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd       (in_cmd_r),
    .byte_in   (in_byte_r),
    .delimiter (delim_r),
    .result    (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

endmodule

FILE: hdl/dmrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrf_checker
// Port-level checks on the receive FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module dmrf_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat straight after reset");

  // with the output side empty the block must be able to take a beat
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  // overflow only happens on a non-empty FIFO
  a_ovf_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> !out_tdata[8])
    else $error("overflow reported on an empty FIFO");

  // overflow always leaves at least one complete message
  a_ovf_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[17:10] != 8'd0)
    else $error("overflow without a counted message");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

endmodule

bind delimited_message_rx_fifo_top dmrf_port_checker u_dmrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
